>>> hdl/pws_pkg.sv
// ----------------------------------------------------------------------------
// pws_pkg
// Shared constants, opcodes, status codes and defaults for the work scheduler.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_FIELD_BITS = 16;

    localparam int IN_W     = 16;
    localparam int TOTAL_W  = 38;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOTAL    = 3'd4;

endpackage

>>> hdl/priority_work_scheduler.sv
// ----------------------------------------------------------------------------
// priority_work_scheduler
// Strict-priority job store with a linear scan over a job memory.
// ----------------------------------------------------------------------------
// Input words (opcode, job_priority, job_units) are taken when in_valid is high
// and in_stall is low; one result word (status, served_priority,
// remaining_total) leaves per input word through an output register, taken when
// out_valid is high and out_stall is low.
// Steps from acceptance to result:
//   arrive stored: job written and product registered, then total updated;
//   arrive rejected or zero units, finish, unused opcode: result registered;
//   tick: the job memory is read one entry a cycle to find the best job, then
//   one write back (on removal, a read of the last entry moved into its slot).
// One word is in work at a time; in_stall is high while a word is in work or a
// result is still held. A stalled receiver holds the result in place.
// Reset empties the store (job count and running total cleared); memory
// contents need no clearing since only counted entries are ever used.
// ----------------------------------------------------------------------------
module priority_work_scheduler #(
    parameter int CAPACITY   = pws_pkg::DEF_CAPACITY,
    parameter int FIELD_BITS = pws_pkg::DEF_FIELD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pws_pkg::OP_W-1:0]  opcode,
    input  logic [pws_pkg::IN_W-1:0]  job_priority,
    input  logic [pws_pkg::IN_W-1:0]  job_units,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pws_pkg::STATUS_W-1:0] status,
    output logic [pws_pkg::IN_W-1:0]  served_priority,
    output logic [pws_pkg::TOTAL_W-1:0] remaining_total
);
    import pws_pkg::*;

    localparam int FB     = FIELD_BITS;
    localparam int WORD_W = 2 * FB;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_MOVE1 = 3'd4;
    localparam logic [2:0] S_MOVE2 = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                rdv_reg, rdv_next;
    logic [CNT_W-1:0]    cidx_reg, cidx_next;
    logic [WORD_W-1:0]   best_reg, best_next;
    logic [ADDR_W-1:0]   bidx_reg, bidx_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IN_W-1:0]     served_reg, served_next;
    logic [TOTAL_W-1:0]  rtot_reg, rtot_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [WORD_W-1:0]   wr_data, rd_data;
    logic                accept, out_take;
    logic [FB-1:0]       pri_in, units_in, best_pri, best_units, units_dec;
    logic [CNT_W-1:0]    last_idx;

    pws_store #(
        .DEPTH  (CAPACITY),
        .WORD_W (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign pri_in    = FB'(job_priority);
    assign units_in  = FB'(job_units);
    assign best_pri  = best_reg[WORD_W-1:FB];
    assign best_units = best_reg[FB-1:0];
    assign units_dec = best_units - FB'(1);
    assign last_idx  = count_reg - CNT_W'(1);

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign served_priority = served_reg;
    assign remaining_total = rtot_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        scan_next      = scan_reg;
        rdv_next       = 1'b0;
        cidx_next      = cidx_reg;
        best_next      = best_reg;
        bidx_next      = bidx_reg;
        out_valid_next = out_valid_reg && !out_take;
        status_next    = status_reg;
        served_next    = served_reg;
        rtot_next      = rtot_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = {pri_in, units_in};
        rd_addr        = scan_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    served_next = '0;
                    priority case (1'b1)
                        opcode == OP_ARRIVE:
                        begin
                            status_next = ST_ACCEPTED;
                            if (count_reg >= CAP_C)
                            begin
                                status_next    = ST_REJECTED;
                                rtot_next      = total_reg;
                                out_valid_next = 1'b1;
                            end
                            else if (units_in != '0)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                prod_next  = WORD_W'(pri_in) * WORD_W'(units_in);
                                state_next = S_ADD;
                            end
                            else
                            begin
                                rtot_next      = total_reg;
                                out_valid_next = 1'b1;
                            end
                        end
                        opcode == OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next    = ST_IDLE;
                                rtot_next      = total_reg;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                cidx_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        opcode == OP_FINISH:
                        begin
                            status_next    = ST_TOTAL;
                            rtot_next      = total_reg;
                            out_valid_next = 1'b1;
                            count_next     = '0;
                            total_next     = '0;
                        end
                        default:
                        begin
                            status_next    = ST_IDLE;
                            rtot_next      = total_reg;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                total_next     = total_reg + TOTAL_W'(prod_reg);
                rtot_next      = total_reg + TOTAL_W'(prod_reg);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_reg != count_reg)
                begin
                    rdv_next  = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (rdv_reg)
                begin
                    cidx_next = cidx_reg + CNT_W'(1);
                    if (cidx_reg == '0 || rd_data > best_reg)
                    begin
                        best_next = rd_data;
                        bidx_next = cidx_reg[ADDR_W-1:0];
                    end
                end
                if (scan_reg == count_reg && !rdv_reg)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                total_next  = total_reg - TOTAL_W'(best_pri);
                status_next = ST_SERVED;
                served_next = IN_W'(best_pri);
                rd_addr     = last_idx[ADDR_W-1:0];
                if (units_dec != '0)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = bidx_reg;
                    wr_data        = {best_pri, units_dec};
                    rtot_next      = total_reg - TOTAL_W'(best_pri);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_MOVE1;
                end
            end
            S_MOVE1:
            begin
                rd_addr    = last_idx[ADDR_W-1:0];
                state_next = S_MOVE2;
            end
            S_MOVE2:
            begin
                wr_en          = 1'b1;
                wr_addr        = bidx_reg;
                wr_data        = rd_data;
                count_next     = last_idx;
                rtot_next      = total_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        scan_reg   <= scan_next;
        cidx_reg   <= cidx_next;
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        status_reg <= status_next;
        served_reg <= served_next;
        rtot_reg   <= rtot_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("job count above capacity");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_FINISH) |=> (count_reg == '0 && total_reg == '0))
        else $error("finish did not clear store");

    a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_SERVED) |-> (served_reg == '0))
        else $error("served priority set on non-serve result");

endmodule

>>> hdl/pws_store.sv
// ----------------------------------------------------------------------------
// pws_store
// Job memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pws_store #(
    parameter int DEPTH  = 64,
    parameter int WORD_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> bench/priority_work_scheduler_test.sv
// ----------------------------------------------------------------------------
// priority_work_scheduler_test
// Drives arrive, tick and finish words into the scheduler under random idling
// on both sides, predicts every result word from an own model of the job
// store, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module priority_work_scheduler_test;
    import pws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_JOBS = DEF_CAPACITY;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IN_W-1:0]     pri;
        logic [TOTAL_W-1:0]  total;
    } sched_result_t;

    class schedule_board;
        logic [IN_W-1:0]    job_pri[NUM_JOBS];
        logic [IN_W-1:0]    job_left[NUM_JOBS];
        int                 jobs_held;
        logic [TOTAL_W-1:0] weight_sum = '0;
        sched_result_t      pending[$];
        int                 mismatches;
        int                 served_words;
        int                 rejects;

        function void note_word(logic [OP_W-1:0] op, logic [IN_W-1:0] pri,
                                logic [IN_W-1:0] units);
            sched_result_t r;
            int best;
            r.pri = '0;
            if (op == OP_ARRIVE) begin
                if (jobs_held >= NUM_JOBS) begin
                    r.status = ST_REJECTED;
                end else begin
                    if (units != 0) begin
                        job_pri[jobs_held] = pri;
                        job_left[jobs_held] = units;
                        jobs_held++;
                        weight_sum = weight_sum + TOTAL_W'(pri) * TOTAL_W'(units);
                    end
                    r.status = ST_ACCEPTED;
                end
                r.total = weight_sum;
            end else if (op == OP_TICK) begin
                if (jobs_held == 0) begin
                    r.status = ST_IDLE;
                end else begin
                    best = 0;
                    for (int i = 1; i < jobs_held; i++)
                        if (job_pri[i] > job_pri[best] ||
                            (job_pri[i] == job_pri[best] && job_left[i] > job_left[best]))
                            best = i;
                    r.status = ST_SERVED;
                    r.pri = job_pri[best];
                    job_left[best]--;
                    weight_sum = weight_sum - TOTAL_W'(job_pri[best]);
                    if (job_left[best] == 0) begin
                        jobs_held--;
                        job_pri[best] = job_pri[jobs_held];
                        job_left[best] = job_left[jobs_held];
                    end
                end
                r.total = weight_sum;
            end else if (op == OP_FINISH) begin
                r.status = ST_TOTAL;
                r.total = weight_sum;
                jobs_held = 0;
                weight_sum = '0;
            end else begin
                r.status = ST_IDLE;
                r.total = weight_sum;
            end
            pending.push_back(r);
        endfunction

        function void check_word(logic [STATUS_W-1:0] st, logic [IN_W-1:0] pri,
                                 logic [TOTAL_W-1:0] total);
            sched_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d pri %0d total %0d",
                             st, pri, total);
                return;
            end
            e = pending.pop_front();
            if (st == ST_SERVED) served_words++;
            if (st == ST_REJECTED) rejects++;
            if (st !== e.status || pri !== e.pri || total !== e.total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             e.status, e.pri, e.total, st, pri, total);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode = OP_ARRIVE;
    logic [IN_W-1:0]     job_priority = '0;
    logic [IN_W-1:0]     job_units = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IN_W-1:0]     served_priority;
    logic [TOTAL_W-1:0]  remaining_total;

    schedule_board board = new();
    bit  quiet = 1'b0;
    int  words_sent = 0;
    longint cycles = 0;

    priority_work_scheduler dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2_000_000)
        begin
            $display("timeout at cycle %0d", cycles);
            $display("status: fail");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            board.check_word(status, served_priority, remaining_total);
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic send_word(logic [OP_W-1:0] op, logic [IN_W-1:0] pri,
                             logic [IN_W-1:0] units);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        job_priority <= pri;
        job_units <= units;
        do @(posedge clk); while (in_stall);
        board.note_word(op, pri, units);
        words_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int kind;
        logic [OP_W-1:0] op;
        logic [IN_W-1:0] p, u;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty tick, extremes, zero units, tie break, unused opcode
        send_word(OP_TICK, 16'hFFFF, 16'hFFFF);
        send_word(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_word(OP_ARRIVE, 16'h0000, 16'h0001);
        send_word(OP_ARRIVE, 16'h1234, 16'h0000);
        send_word(OP_ARRIVE, 16'h0100, 16'h0002);
        send_word(OP_ARRIVE, 16'h0100, 16'h0005);
        send_word(2'd3, 16'hAAAA, 16'h5555);
        send_word(OP_TICK, '0, '0);
        send_word(OP_TICK, '0, '0);
        send_word(OP_FINISH, 16'h5555, 16'hAAAA);
        send_word(OP_TICK, '0, '0);
        send_word(OP_ARRIVE, 16'h0007, 16'h0001);
        send_word(OP_TICK, '0, '0);
        send_word(OP_TICK, '0, '0);
        // fill the store, then overflow it
        for (int i = 0; i < NUM_JOBS + 3; i++)
            send_word(OP_ARRIVE, 16'($urandom), 16'hFFFF);
        send_word(OP_TICK, '0, '0);
        send_word(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_word(OP_FINISH, '0, '0);

        // random: mostly small jobs and ticks so jobs drain and leave
        for (int i = 0; i < 1150; i++)
        begin
            if (i > 1050) quiet = 1'b1;
            kind = $urandom_range(0, 99);
            p = 16'($urandom);
            u = 16'($urandom);
            if (kind < 40)
            begin
                op = OP_ARRIVE;
                if ($urandom_range(0, 3) != 0) p = 16'($urandom_range(0, 7));
                if ($urandom_range(0, 9) != 0) u = 16'($urandom_range(0, 4));
            end
            else if (kind < 95) op = OP_TICK;
            else if (kind < 98) op = OP_FINISH;
            else op = 2'd3;
            send_word(op, p, u);
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (NUM_JOBS + 20) @(posedge clk);
        $display("sent %0d words; %0d units served, %0d arrivals rejected",
                 words_sent, board.served_words, board.rejects);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> priority_work_scheduler.f
hdl/pws_pkg.sv
hdl/pws_store.sv
hdl/priority_work_scheduler.sv
bench/priority_work_scheduler_test.sv
